>>> rtl/d1x_pkg.sv
// ----------------------------------------------------------------------------
// d1x_pkg
// Shared types and constants of the supplicant backend state machine.
// ----------------------------------------------------------------------------
package d1x_pkg;

	// Default width of the authentication countdown.
	localparam int TIMER_BITS_DEF = 16;

	// Configuration register port.
	localparam int CFG_DATA_BITS  = 16;
	localparam int CFG_INDEX_BITS = 1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_AUTH_PERIOD   = 1'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_WIRELESS_PORT = 1'd1;

	// Reset value of the authentication period register.
	localparam logic [15:0] AUTH_PERIOD_RST = 16'd30;

	// Command codes of an input transaction.
	localparam logic CMD_EVAL = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	// State codes as reported on the result.
	localparam logic [2:0] CODE_INIT     = 3'd0;
	localparam logic [2:0] CODE_IDLE     = 3'd1;
	localparam logic [2:0] CODE_REQUEST  = 3'd2;
	localparam logic [2:0] CODE_RESPONSE = 3'd3;
	localparam logic [2:0] CODE_RECEIVE  = 3'd4;
	localparam logic [2:0] CODE_FAIL     = 3'd5;
	localparam logic [2:0] CODE_TIMEOUT  = 3'd6;
	localparam logic [2:0] CODE_SUCCESS  = 3'd7;

	// Resting states; the transient states pass through within one step.
	typedef enum logic [3:0] {
		ST_INIT    = 4'b0001,
		ST_IDLE    = 4'b0010,
		ST_REQUEST = 4'b0100,
		ST_RECEIVE = 4'b1000
	} state_t;

	// One input transaction.
	typedef struct packed {
		logic command;
		logic init_request;
		logic abort_request;
		logic restart_request;
		logic frame_arrived;
		logic start_set;
		logic eap_failed;
		logic eap_succeeded;
		logic eap_has_response;
		logic eap_no_response;
	} in_item_t;

	// Pulses of one result transaction.
	typedef struct packed {
		logic eap_request_pulse;
		logic response_sent;
		logic fail_pulse;
		logic success_pulse;
		logic timeout_pulse;
		logic disassociate;
		logic abort_pulse;
	} pulses_t;

	// Code of a resting state.
	function automatic logic [2:0] state_code(input state_t s);
		logic [2:0] c;
		unique case (s)
			ST_INIT:    c = CODE_INIT;
			ST_IDLE:    c = CODE_IDLE;
			ST_REQUEST: c = CODE_REQUEST;
			ST_RECEIVE: c = CODE_RECEIVE;
			default:    c = CODE_IDLE;
		endcase
		return c;
	endfunction

endpackage

>>> rtl/d1x_be_next.sv
// ----------------------------------------------------------------------------
// d1x_be_next
// Next-state logic: one evaluate step or one timer tick of the backend.
// ----------------------------------------------------------------------------
module d1x_be_next #(
	parameter int TIMER_BITS = d1x_pkg::TIMER_BITS_DEF
) (
	input  d1x_pkg::in_item_t       item,
	input  d1x_pkg::state_t         state,
	input  logic [TIMER_BITS-1:0]   countdown,
	input  logic                    frame_pending,
	input  logic                    start_pending,
	input  logic [15:0]             auth_period,
	input  logic                    wireless_port,
	output d1x_pkg::state_t         state_nxt,
	output logic [TIMER_BITS-1:0]   countdown_nxt,
	output logic                    frame_pending_nxt,
	output logic                    start_pending_nxt,
	output d1x_pkg::pulses_t        pulses
);

	logic [TIMER_BITS+15:0] period_ext;
	logic [TIMER_BITS-1:0]  period_load;
	logic                   fp;
	logic                   sp;
	logic                   global_reset;

	// The period register is masked or zero-extended to the countdown width.
	assign period_ext  = {{TIMER_BITS{1'b0}}, auth_period};
	assign period_load = period_ext[TIMER_BITS-1:0];

	// Latched pulses take effect before the transitions are tested.
	assign fp = frame_pending | item.frame_arrived;
	assign sp = start_pending | item.start_set;
	assign global_reset = item.init_request | item.abort_request | item.restart_request;

	// Transitions take the first matching condition in priority order.
	always_comb begin
		state_nxt         = state;
		countdown_nxt     = countdown;
		frame_pending_nxt = frame_pending;
		start_pending_nxt = start_pending;
		pulses            = '0;
		if (item.command == d1x_pkg::CMD_TICK) begin
			if (countdown != '0) begin
				countdown_nxt = countdown - 1'b1;
			end
		end else begin
			frame_pending_nxt = fp;
			start_pending_nxt = sp;
			if (global_reset) begin
				pulses.abort_pulse = 1'b1;
				start_pending_nxt  = 1'b0;
				state_nxt          = d1x_pkg::ST_IDLE;
			end else begin
				unique case (state)
					d1x_pkg::ST_INIT: begin
						state_nxt = d1x_pkg::ST_INIT;
					end
					d1x_pkg::ST_IDLE: begin
						if (item.eap_failed && sp) begin
							pulses.fail_pulse = 1'b1;
							start_pending_nxt = 1'b0;
						end else if (fp && sp) begin
							pulses.eap_request_pulse = 1'b1;
							countdown_nxt            = '0;
							state_nxt                = d1x_pkg::ST_REQUEST;
						end else if (item.eap_succeeded && sp) begin
							pulses.success_pulse = 1'b1;
							start_pending_nxt    = 1'b0;
						end
					end
					d1x_pkg::ST_REQUEST: begin
						if (item.eap_failed) begin
							pulses.fail_pulse = 1'b1;
							start_pending_nxt = 1'b0;
							state_nxt         = d1x_pkg::ST_IDLE;
						end else if (item.eap_no_response) begin
							countdown_nxt     = period_load;
							frame_pending_nxt = 1'b0;
							state_nxt         = d1x_pkg::ST_RECEIVE;
						end else if (item.eap_has_response) begin
							pulses.response_sent = 1'b1;
							countdown_nxt        = period_load;
							frame_pending_nxt    = 1'b0;
							state_nxt            = d1x_pkg::ST_RECEIVE;
						end else if (item.eap_succeeded) begin
							pulses.success_pulse = 1'b1;
							start_pending_nxt    = 1'b0;
							state_nxt            = d1x_pkg::ST_IDLE;
						end
					end
					d1x_pkg::ST_RECEIVE: begin
						if (item.eap_failed) begin
							pulses.fail_pulse = 1'b1;
							start_pending_nxt = 1'b0;
							state_nxt         = d1x_pkg::ST_IDLE;
						end else if (countdown == '0) begin
							pulses.timeout_pulse = 1'b1;
							pulses.disassociate  = wireless_port;
							start_pending_nxt    = 1'b0;
							state_nxt            = d1x_pkg::ST_IDLE;
						end else if (item.eap_succeeded) begin
							pulses.success_pulse = 1'b1;
							start_pending_nxt    = 1'b0;
							state_nxt            = d1x_pkg::ST_IDLE;
						end else if (fp) begin
							pulses.eap_request_pulse = 1'b1;
							countdown_nxt            = '0;
							state_nxt                = d1x_pkg::ST_REQUEST;
						end
					end
					default: begin
						start_pending_nxt = 1'b0;
						state_nxt         = d1x_pkg::ST_IDLE;
					end
				endcase
			end
		end
	end

endmodule

>>> rtl/dot1x_supplicant_backend_fsm.sv
// ----------------------------------------------------------------------------
// dot1x_supplicant_backend_fsm
// 802.1X supplicant backend state machine with authentication countdown.
// ----------------------------------------------------------------------------
//  channel | handshake                  | payload
//  --------+----------------------------+-----------------------------------
//  in      | in_valid / in_stall        | command, request and EAP flags
//  out     | out_valid / out_stall      | state_code, pulses, countdown_now
//  config  | cfg_write_en, cfg_index    | cfg_data (16 bits)
//
//  One transaction per cycle while the output does not stall: an input
//  register feeds the step logic, and the result is registered in the
//  output register, and steps follow back to back.
//  Reset puts the machine in initialize with the countdown and flags clear.
//  A stall on the output holds the result and backs up into the input stall.
// ----------------------------------------------------------------------------
module dot1x_supplicant_backend_fsm #(
	parameter int TIMER_BITS = d1x_pkg::TIMER_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Configuration port.
	input  logic                                 cfg_write_en,
	input  logic [d1x_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [d1x_pkg::CFG_DATA_BITS-1:0]    cfg_data,
	// Input channel.
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 command,
	input  logic                                 init_request,
	input  logic                                 abort_request,
	input  logic                                 restart_request,
	input  logic                                 frame_arrived,
	input  logic                                 start_set,
	input  logic                                 eap_failed,
	input  logic                                 eap_succeeded,
	input  logic                                 eap_has_response,
	input  logic                                 eap_no_response,
	// Output channel.
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [2:0]                           state_code,
	output logic                                 eap_request_pulse,
	output logic                                 response_sent,
	output logic                                 fail_pulse,
	output logic                                 success_pulse,
	output logic                                 timeout_pulse,
	output logic                                 disassociate,
	output logic                                 abort_pulse,
	output logic [15:0]                          countdown_now
);

	logic [15:0]             auth_period_q;
	logic                    wireless_port_q;
	d1x_pkg::state_t         state_q;
	logic [TIMER_BITS-1:0]   countdown_q;
	logic                    frame_pending_q;
	logic                    start_pending_q;
	logic                    valid_s1;
	d1x_pkg::in_item_t       item_s1;
	d1x_pkg::in_item_t       item_in;
	logic                    out_valid_q;
	logic                    advance;
	logic                    load_s1;
	d1x_pkg::state_t         state_nxt;
	logic [TIMER_BITS-1:0]   countdown_nxt;
	logic                    frame_pending_nxt;
	logic                    start_pending_nxt;
	d1x_pkg::pulses_t        pulses_nxt;
	d1x_pkg::pulses_t        pulses_q;
	logic [2:0]              code_q;
	logic [TIMER_BITS+15:0]  countdown_ext;
	logic [15:0]             countdown_q16;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			auth_period_q   <= d1x_pkg::AUTH_PERIOD_RST;
			wireless_port_q <= 1'b0;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				d1x_pkg::CFG_AUTH_PERIOD:   auth_period_q   <= cfg_data;
				d1x_pkg::CFG_WIRELESS_PORT: wireless_port_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Handshake: the step runs when the result register is free or emptying.
	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign load_s1  = in_valid && !in_stall;

	assign item_in = '{
		command:          command,
		init_request:     init_request,
		abort_request:    abort_request,
		restart_request:  restart_request,
		frame_arrived:    frame_arrived,
		start_set:        start_set,
		eap_failed:       eap_failed,
		eap_succeeded:    eap_succeeded,
		eap_has_response: eap_has_response,
		eap_no_response:  eap_no_response
	};

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			item_s1 <= item_in;
		end
	end

	// Step logic.
	d1x_be_next #(
		.TIMER_BITS (TIMER_BITS)
	) u_next (
		.item              (item_s1),
		.state             (state_q),
		.countdown         (countdown_q),
		.frame_pending     (frame_pending_q),
		.start_pending     (start_pending_q),
		.auth_period       (auth_period_q),
		.wireless_port     (wireless_port_q),
		.state_nxt         (state_nxt),
		.countdown_nxt     (countdown_nxt),
		.frame_pending_nxt (frame_pending_nxt),
		.start_pending_nxt (start_pending_nxt),
		.pulses            (pulses_nxt)
	);

	// Machine state, updated once per processed transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= d1x_pkg::ST_INIT;
			countdown_q     <= '0;
			frame_pending_q <= 1'b0;
			start_pending_q <= 1'b0;
		end else if (valid_s1 && advance) begin
			state_q         <= state_nxt;
			countdown_q     <= countdown_nxt;
			frame_pending_q <= frame_pending_nxt;
			start_pending_q <= start_pending_nxt;
		end
	end

	// Countdown as reported: low 16 bits, zero-extended for narrow timers.
	assign countdown_ext = {16'b0, countdown_nxt};
	assign countdown_q16 = countdown_ext[15:0];

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			code_q        <= d1x_pkg::state_code(state_nxt);
			pulses_q      <= pulses_nxt;
			countdown_now <= countdown_q16;
		end
	end

	assign out_valid         = out_valid_q;
	assign state_code        = code_q;
	assign eap_request_pulse = pulses_q.eap_request_pulse;
	assign response_sent     = pulses_q.response_sent;
	assign fail_pulse        = pulses_q.fail_pulse;
	assign success_pulse     = pulses_q.success_pulse;
	assign timeout_pulse     = pulses_q.timeout_pulse;
	assign disassociate      = pulses_q.disassociate;
	assign abort_pulse       = pulses_q.abort_pulse;

endmodule
